// ===== hw/rtl/prf_pkg.sv =====
// Shared types and constants for the page replacement unit.
package prf_pkg;

  localparam int unsigned FRAMES     = 8;
  localparam int unsigned PAGE_BITS  = 16;
  localparam int unsigned IDX_W      = $clog2(FRAMES);
  localparam int unsigned CNT_W      = $clog2(FRAMES + 1);
  localparam int unsigned RANK_W     = IDX_W;
  localparam int unsigned RANK_MAX   = FRAMES - 1;
  localparam int unsigned FAULT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned NFRAME_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = CFG_IDX_W'(1);

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Running result handed from cell to cell during the lookup sweep.
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic [RANK_W-1:0]    best_rank;
    logic [IDX_W-1:0]     best_idx;
    logic                 best_valid;
    logic [PAGE_BITS-1:0] best_page;
    logic                 fv_valid;
    logic [PAGE_BITS-1:0] fv_page;
  } scan_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                 clear;
    logic                 scan_en;
    logic [IDX_W-1:0]     scan_idx;
    logic                 commit;
    logic                 fault;
    logic [IDX_W-1:0]     frame;
    logic [RANK_W-1:0]    old_rank;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     active_n;
    logic [IDX_W-1:0]     fifo_frame;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/page_replacement_fifo_lru_top.sv =====
// Page replacement unit: sequencer, registers and the chain of frame cells.
//
// Usage: page references arrive on the in channel (page_id_i, restart_i) under
// in_valid_i / in_stall_o, one result per reference leaves on the out channel
// (hit, frame, evicted page, fault count) under out_valid_o / out_stall_i.
// Registers policy_mode (index 0) and frames_in_use (index 1) are written on
// the cfg channel, which is always ready; write them only while idle.
// A request is swept through the frame cells one cell per cycle, and no new
// request is taken until the previous one has left the commit state. The
// sweep length is set by the cell chain, which carries the lookup and the LRU
// victim search.
// A restart request empties frames, ranks, FIFO pointer and fault count
// before its lookup; the registers keep their values.
// Reset empties everything and sets FIFO mode with all frames in use.
// While the receiver stalls, the result holds in the output register and
// the next request waits in the commit state until the register frees.
module page_replacement_fifo_lru_top import prf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PAGE_BITS-1:0]  page_id_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [IDX_W-1:0]      frame_index_o,
  output logic                  evicted_valid_o,
  output logic [PAGE_BITS-1:0]  evicted_page_o,
  output logic [FAULT_W-1:0]    fault_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic                 policy_q;
  logic [NFRAME_W-1:0]  frames_q;
  logic [IDX_W-1:0]     oldest_q;
  logic [CNT_W-1:0]     filled_q;
  logic [FAULT_W-1:0]   faults_q, faults_d;
  logic [PAGE_BITS-1:0] ref_page_q;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [IDX_W-1:0]     scan_idx_q;

  logic                 out_valid_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     frame_q;
  logic                 ev_valid_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [FAULT_W-1:0]   faults_out_q;

  logic                 in_acc;
  logic                 clear;
  logic                 out_free;
  logic                 commit;
  logic                 fault;
  logic                 filling;
  logic [IDX_W-1:0]     fifo_f, fifo_next;
  logic [IDX_W-1:0]     frame_d;
  logic                 ev_d;
  logic [PAGE_BITS-1:0] evp_d;
  scan_t                res;
  cell_ctl_t            ctl;
  scan_t                carry_w [FRAMES];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign clear       = in_acc && restart_i;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit      = (state_q == ST_COMMIT) && out_free;
  assign res         = carry_w[FRAMES-1];
  assign fault       = !res.hit;
  assign filling     = filled_q < n_q;

  // Active frame count, clamped to one and to the number of cells.
  always_comb begin
    if (frames_q == '0) begin
      n_d = CNT_W'(1);
    end else if (32'(frames_q) > FRAMES) begin
      n_d = CNT_W'(FRAMES);
    end else begin
      n_d = CNT_W'(frames_q);
    end
  end

  always_comb begin
    fifo_f = (CNT_W'(oldest_q) < n_q) ? oldest_q : '0;
    fifo_next = ((CNT_W'(fifo_f) + CNT_W'(1)) >= n_q) ? '0 : fifo_f + IDX_W'(1);
  end

  always_comb begin
    frame_d = res.hit_idx;
    ev_d    = 1'b0;
    evp_d   = '0;
    if (fault) begin
      if (filling) begin
        frame_d = filled_q[IDX_W-1:0];
      end else if (policy_q == POLICY_FIFO) begin
        frame_d = fifo_f;
        ev_d    = res.fv_valid;
        evp_d   = res.fv_valid ? res.fv_page : '0;
      end else begin
        frame_d = res.best_idx;
        ev_d    = res.best_valid;
        evp_d   = res.best_valid ? res.best_page : '0;
      end
    end
  end

  assign faults_d = (fault && (faults_q != '1)) ? faults_q + FAULT_W'(1) : faults_q;

  always_comb begin
    ctl.clear      = clear;
    ctl.scan_en    = (state_q == ST_SCAN);
    ctl.scan_idx   = scan_idx_q;
    ctl.commit     = commit;
    ctl.fault      = fault;
    ctl.frame      = frame_d;
    ctl.old_rank   = res.hit ? res.hit_rank : RANK_W'(RANK_MAX);
    ctl.page       = ref_page_q;
    ctl.active_n   = n_q;
    ctl.fifo_frame = fifo_f;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_q == IDX_W'(FRAMES - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    scan_t carry_in;
    if (g == 0) begin : g_head
      assign carry_in = '0;
    end else begin : g_link
      assign carry_in = carry_w[g-1];
    end
    prf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl),
      .carry_i (carry_in),
      .carry_o (carry_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POLICY_FIFO;
      frames_q    <= NFRAME_W'(8);
      oldest_q    <= '0;
      filled_q    <= '0;
      faults_q    <= '0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_POLICY_MODE) begin
          policy_q <= cfg_data_i[0];
        end else if (cfg_index_i == REG_FRAMES_IN_USE) begin
          frames_q <= cfg_data_i[NFRAME_W-1:0];
        end
      end
      if (clear) begin
        oldest_q <= '0;
        filled_q <= '0;
        faults_q <= '0;
      end else if (commit) begin
        faults_q <= faults_d;
        if (fault && filling) begin
          filled_q <= filled_q + CNT_W'(1);
        end else if (fault && (policy_q == POLICY_FIFO)) begin
          oldest_q <= fifo_next;
        end
      end
      if (in_acc) begin
        scan_idx_q <= '0;
      end else if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      // hold the result until the receiver takes it
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ref_page_q <= page_id_i;
      n_q        <= n_d;
    end
    if (commit) begin
      hit_q        <= res.hit;
      frame_q      <= frame_d;
      ev_valid_q   <= ev_d;
      ev_page_q    <= evp_d;
      faults_out_q <= faults_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = faults_out_q;

`ifndef SYNTH
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("hit result reports an eviction");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page not zero without eviction");

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(filled_q) <= FRAMES)
    else $error("fill count beyond frame count");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && fault && (faults_q != '1) |=> faults_q == $past(faults_q) + FAULT_W'(1))
    else $error("fault not counted");

  a_wait_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) && out_valid_q && out_stall_i |=> state_q == ST_COMMIT)
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/prf_cell.sv =====
// One page frame: stored page, valid bit, recency rank and a lookup stage.
module prf_cell import prf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctl_t        ctl_i,
  input  scan_t            carry_i,
  output scan_t            carry_o
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q;
  scan_t                carry_q, carry_d;
  logic                 active;
  logic                 match;
  logic                 mine;

  assign active  = CNT_W'(idx_i) < ctl_i.active_n;
  assign match   = active && valid_q && (page_q == ctl_i.page);
  assign mine    = (idx_i == ctl_i.frame);
  assign carry_o = carry_q;

  always_comb begin
    carry_d = carry_i;
    if (match && !carry_i.hit) begin
      carry_d.hit      = 1'b1;
      carry_d.hit_idx  = idx_i;
      carry_d.hit_rank = rank_q;
    end
    // Frame 0 seeds the victim search; later frames win only on a strictly older rank.
    if (active && ((rank_q > carry_i.best_rank) || (idx_i == '0))) begin
      carry_d.best_rank  = rank_q;
      carry_d.best_idx   = idx_i;
      carry_d.best_valid = valid_q;
      carry_d.best_page  = page_q;
    end
    if (idx_i == ctl_i.fifo_frame) begin
      carry_d.fv_valid = valid_q;
      carry_d.fv_page  = page_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_en && (ctl_i.scan_idx == idx_i)) begin
      carry_q <= carry_d;
    end
    if (ctl_i.commit && ctl_i.fault && mine) begin
      page_q <= ctl_i.page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (ctl_i.clear) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (ctl_i.commit) begin
      if (mine) begin
        rank_q <= '0;
        if (ctl_i.fault) begin
          valid_q <= 1'b1;
        end
      end else if (active && valid_q && (rank_q <= ctl_i.old_rank) &&
                   (rank_q != RANK_W'(RANK_MAX))) begin
        // age frames that were more recent than the touched one
        rank_q <= rank_q + RANK_W'(1);
      end
    end
  end

endmodule

// ===== bench/tb_page_replacement_fifo_lru_top.sv =====
// Self-checking bench for the FIFO/LRU page replacement unit, with a model of its own.
module tb_page_replacement_fifo_lru_top;
  import prf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_REQS  = 155;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 restart;
  } page_req_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame;
    logic                 evicted;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   faults;
  } frame_outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PAGE_BITS-1:0]  page_id_i = '0;
  logic                  restart_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [IDX_W-1:0]      frame_index_o;
  logic                  evicted_valid_o;
  logic [PAGE_BITS-1:0]  evicted_page_o;
  logic [FAULT_W-1:0]    fault_count_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  page_replacement_fifo_lru_top dut (.*);

  // Shadow of the frame set and its registers
  logic [PAGE_BITS-1:0] shadow_page [FRAMES];
  logic                 shadow_valid [FRAMES];
  logic [RANK_W-1:0]    shadow_rank [FRAMES];
  int unsigned          fifo_ptr;
  int unsigned          fill_count;
  logic [FAULT_W-1:0]   fault_total;
  logic                 policy;
  logic [NFRAME_W-1:0]  frames_reg;

  page_req_t      queued_pages [$];
  frame_outcome_t pending_outcomes [$];
  page_req_t      next_req;
  frame_outcome_t want;
  int unsigned    send_idle_pct = 22;
  int unsigned    recv_idle_pct = 46;
  int unsigned    quiet_cycles = 0;
  int unsigned    mismatches = 0;
  logic                  phase_policy [PHASES];
  logic [CFG_DATA_W-1:0] phase_frames [PHASES];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void empty_frames();
    int i;
    for (i = 0; i < FRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = '0;
    end
    fifo_ptr    = 0;
    fill_count  = 0;
    fault_total = '0;
  endfunction

  function automatic frame_outcome_t resolve_reference(logic [PAGE_BITS-1:0] page,
                                                       logic restart);
    frame_outcome_t res;
    int unsigned    n, f, best, i;
    logic           found;
    logic [RANK_W-1:0] prev;
    res = '0;
    if (restart) empty_frames();
    n = frames_reg;
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    found = 1'b0;
    f = 0;
    for (i = 0; i < n; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == page) begin
        found = 1'b1;
        f = i;
      end
    end
    if (!found) begin
      if (fault_total != '1) fault_total++;
      if (fill_count < n) begin
        f = fill_count;
        if (f >= FRAMES) f = FRAMES - 1;
        fill_count++;
      end else if (policy == POLICY_FIFO) begin
        // a pointer left beyond a lowered frame count falls back to frame 0
        f = (fifo_ptr < n) ? fifo_ptr : 0;
        fifo_ptr = (f + 1 >= n) ? 0 : f + 1;
      end else begin
        best = 0;
        f = 0;
        for (i = 0; i < n; i++) begin
          if (shadow_rank[i] > best) begin
            best = shadow_rank[i];
            f = i;
          end
        end
      end
      if (shadow_valid[f]) begin
        res.evicted      = 1'b1;
        res.evicted_page = shadow_page[f];
      end
      shadow_rank[f]  = RANK_W'(RANK_MAX);
      shadow_page[f]  = page;
      shadow_valid[f] = 1'b1;
    end
    // age every active frame that was younger than this one
    prev = shadow_rank[f];
    for (i = 0; i < n; i++) begin
      if (i != f && shadow_valid[i] && shadow_rank[i] <= prev && shadow_rank[i] < RANK_MAX)
        shadow_rank[i]++;
    end
    shadow_rank[f] = '0;
    res.hit    = found;
    res.frame  = IDX_W'(f);
    res.faults = fault_total;
    return res;
  endfunction

  function automatic void compare_field(string field, longint unsigned exp_val,
                                        longint unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Request driver: present a new request only once the previous one has gone
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (queued_pages.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = queued_pages.pop_front();
        in_valid_i <= 1'b1;
        page_id_i  <= next_req.page;
        restart_i  <= next_req.restart;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predict on acceptance, check on delivery, track register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_POLICY_MODE:   policy = cfg_data_i[0];
          REG_FRAMES_IN_USE: frames_reg = NFRAME_W'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        pending_outcomes.push_back(resolve_reference(page_id_i, restart_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t ns: result with no request outstanding, expected none, actual frame %0d",
                   $time, frame_index_o);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("hit", want.hit, hit_o);
          compare_field("frame_index", want.frame, frame_index_o);
          compare_field("evicted_valid", want.evicted, evicted_valid_o);
          compare_field("evicted_page", want.evicted_page, evicted_page_o);
          compare_field("fault_count", want.faults, fault_count_o);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic queue_ref(logic [PAGE_BITS-1:0] page, logic restart);
    page_req_t req;
    req.page    = page;
    req.restart = restart;
    queued_pages.push_back(req);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every request has gone through, then let the pipeline settle
  task automatic drain();
    while (queued_pages.size() > 0 || in_valid_i || pending_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (FRAMES + 4) @(posedge clk_i);
  endtask

  // Bursts of references drawn from a small working set, with some noise
  task automatic queue_random_phase(int unsigned count);
    logic [PAGE_BITS-1:0] pool [12];
    int unsigned left, pool_n, burst, k, roll;
    left = count;
    while (left > 0) begin
      pool_n = $urandom_range(1, 12);
      for (k = 0; k < pool_n; k++) pool[k] = PAGE_BITS'($urandom);
      burst = $urandom_range(10, 40);
      if (burst > left) burst = left;
      for (k = 0; k < burst; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2)
          queue_ref(pool[$urandom_range(0, pool_n - 1)], 1'b1);
        else if (roll < 8)
          queue_ref(PAGE_BITS'($urandom), 1'b0);
        else if (roll < 10)
          queue_ref(roll[0] ? '1 : '0, 1'b0);
        else
          queue_ref(pool[$urandom_range(0, pool_n - 1)], 1'b0);
      end
      left -= burst;
    end
  endtask

  initial begin
    int unsigned p, k;
    empty_frames();
    policy     = POLICY_FIFO;
    frames_reg = NFRAME_W'(FRAMES);
    phase_policy = '{POLICY_FIFO, POLICY_LRU, POLICY_LRU, POLICY_FIFO, POLICY_LRU,
                     POLICY_FIFO, POLICY_LRU, POLICY_FIFO, POLICY_LRU, POLICY_FIFO};
    phase_frames = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd5, 4'd8, 4'd2, 4'd7, 4'd4};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // FIFO with all frames: fill, a duplicate while filling, then evict in order
    queue_ref(16'h0000, 1'b0);
    queue_ref(16'hFFFF, 1'b0);
    queue_ref(16'h0000, 1'b0);
    for (k = 1; k <= 6; k++) queue_ref(PAGE_BITS'(k), 1'b0);
    for (k = 7; k <= 11; k++) queue_ref(PAGE_BITS'(k), 1'b0);
    drain();

    // lower the frame count while full: pointer beyond range, upper frames ignored
    write_reg(REG_FRAMES_IN_USE, 4'd3);
    queue_ref(16'h00C0, 1'b0);
    queue_ref(16'h0005, 1'b0);
    drain();

    // LRU with a zero frame count, which behaves as one frame
    write_reg(REG_POLICY_MODE, CFG_DATA_W'(POLICY_LRU));
    write_reg(REG_FRAMES_IN_USE, 4'd0);
    queue_ref(16'h1234, 1'b1);
    queue_ref(16'h1234, 1'b0);
    queue_ref(16'h5678, 1'b0);
    drain();

    // oversized frame count clamps to all frames
    write_reg(REG_FRAMES_IN_USE, 4'd15);
    queue_ref(16'hAAAA, 1'b1);
    queue_ref(16'h5555, 1'b0);
    queue_ref(16'hAAAA, 1'b0);
    queue_ref(16'h8001, 1'b0);
    drain();

    for (p = 0; p < PHASES; p++) begin
      write_reg(REG_POLICY_MODE, CFG_DATA_W'(phase_policy[p]));
      write_reg(REG_FRAMES_IN_USE, phase_frames[p]);
      if (p < 4) begin
        send_idle_pct = 22;
        recv_idle_pct = 46;
      end else if (p < 7) begin
        send_idle_pct = 46;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_random_phase(PHASE_REQS);
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
